// File: hw/rtl/biquad_bandpass_cascade_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the biquad band-pass cascade
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_BANDPASS_CASCADE_TOP_MACROS_SVH
`define BIQUAD_BANDPASS_CASCADE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bbc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bbc assertion failed");

`endif

// File: hw/rtl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Biquad band-pass cascade package
// Shared constants, register index codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

    // Default sizing of the cascade.
    localparam int NUM_SECTIONS_DEF = 4;
    localparam int SAMPLE_BITS_DEF  = 24;

    // Fixed-point format constants.
    localparam int GUARD_FRAC     = 8;
    localparam int DELAY_EXTRA    = 16;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC      = 30;
    localparam int CFG_INDEX_BITS = 3;

    // Coefficient reset values (1.0 for b0, 0.0 for the feedback terms).
    localparam logic signed [COEF_BITS-1:0] B0_RESET = 32'sh4000_0000;
    localparam logic signed [COEF_BITS-1:0] A_RESET  = 32'sh0000_0000;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HP_B0 = 3'd0,
        CFG_HP_A1 = 3'd1,
        CFG_HP_A2 = 3'd2,
        CFG_LP_B0 = 3'd3,
        CFG_LP_A1 = 3'd4,
        CFG_LP_A2 = 3'd5
    } cfg_index_t;

    // Sequencer states: one pass through S_XLO .. S_WR per section.
    typedef enum logic [3:0] {
        S_IDLE,
        S_XLO,
        S_XHI,
        S_XACC,
        S_RND,
        S_Y,
        S_A1LO,
        S_A1HI,
        S_A2LO,
        S_A2HI,
        S_A2ACC,
        S_WR
    } state_t;

endpackage

// File: hw/rtl/biquad_bandpass_cascade_top.sv
// ----------------------------------------------------------------------------
// Biquad band-pass cascade
// NUM_SECTIONS transposed direct form II biquads in series on one multiplier.
// ----------------------------------------------------------------------------
// The block filters one signed sample per request through NUM_SECTIONS biquad
// sections: the first NUM_SECTIONS/2 are high-pass, the rest low-pass, with
// b0, a1 and a2 of each type programmed in Q2.30 over the configuration port.
// in_stall is high while a request is in work, until its result retires, so the
// block takes no new sample before it is through with the last. The time is
// set by the single shared multiplier: each section needs three products
// (x * b0, y * a1, y * a2), each formed in two half-word passes and
// accumulated, plus rounding, saturation and the delay write-back. If the
// previous result is still waiting when the next one is ready, the final
// step holds until the output register frees.
`timescale 1ns / 1ps

module biquad_bandpass_cascade_top
    import bbc_pkg::*;
#(
    parameter int NUM_SECTIONS = NUM_SECTIONS_DEF,
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          clipped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data
);

    // Derived widths.
    localparam int DW = SAMPLE_BITS + DELAY_EXTRA;  // delay word
    localparam int LW = (DW + 1) / 2;               // low half, unsigned
    localparam int HW = DW - LW;                    // high half, signed
    localparam int OW = LW + 1;                     // multiplier operand
    localparam int MW = OW + COEF_BITS;             // partial product
    localparam int AW = DW + COEF_BITS;             // full product
    localparam int SW = DW + 6;                     // section sums
    localparam int KW = $clog2(NUM_SECTIONS);
    localparam int RW = DW + 1 - GUARD_FRAC;        // rounded output

    localparam logic [KW-1:0] HP_SECTIONS = KW'(NUM_SECTIONS / 2);
    localparam logic [KW-1:0] LAST_SEC    = KW'(NUM_SECTIONS - 1);

    // Rounding constants and saturation limits.
    localparam logic signed [AW-1:0] RND_S30 =
        {{(AW - COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC - 1){1'b0}}};
    localparam logic signed [AW-1:0] RND_S29 =
        {{(AW - COEF_FRAC + 1){1'b0}}, 1'b1, {(COEF_FRAC - 2){1'b0}}};
    localparam logic signed [DW:0] RND_OUT =
        {{(DW - GUARD_FRAC + 1){1'b0}}, 1'b1, {(GUARD_FRAC - 1){1'b0}}};
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW - 1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // Saturate a section sum to the delay word range.
    function automatic logic signed [DW-1:0] sat_dw(input logic signed [SW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SW'(DMAX)) begin
            r = DMAX;
        end
        else if (v < SW'(DMIN)) begin
            r = DMIN;
        end
        else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    // Sequencer and datapath registers.
    state_t                       state_reg, state_next;
    logic [KW-1:0]                sec_reg;
    logic signed [DW-1:0]         x_reg;
    logic signed [DW-1:0]         y_reg;
    logic signed [MW-1:0]         mult_reg;
    logic signed [AW-1:0]         acc_reg;
    logic signed [DW+1:0]         pb0_reg;
    logic signed [DW+3:0]         pb1_reg;
    logic signed [DW-1:0]         z1_reg [NUM_SECTIONS];
    logic signed [DW-1:0]         z2_reg [NUM_SECTIONS];

    // Coefficient registers.
    logic signed [COEF_BITS-1:0]  hp_b0_reg, hp_a1_reg, hp_a2_reg;
    logic signed [COEF_BITS-1:0]  lp_b0_reg, lp_a1_reg, lp_a2_reg;

    // Output register.
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                         clipped_reg;

    // Combinational datapath signals.
    logic                         is_hp;
    logic                         sec_last;
    logic                         wr_done;
    logic                         x_phase;
    logic                         lo_phase;
    logic signed [COEF_BITS-1:0]  coef_b0, coef_a1, coef_a2, op_c;
    logic signed [DW-1:0]         mul_src;
    logic signed [HW-1:0]         src_hi;
    logic signed [OW-1:0]         op_a;
    logic signed [MW-1:0]         mul_prod;
    logic signed [AW-1:0]         mult_ext;
    logic signed [AW-1:0]         mult_shift;
    logic signed [AW-1:0]         acc_rb0, acc_rb1;
    logic signed [DW+1:0]         pb0_val;
    logic signed [DW+2:0]         pb1_val;
    logic signed [DW+3:0]         pb1_ext, pb1_next;
    logic signed [DW+1:0]         pa_val;
    logic signed [SW-1:0]         y_sum, n1_sum, n2_sum;
    logic signed [DW:0]           out_sum;
    logic signed [RW-1:0]         out_rnd;
    logic signed [SAMPLE_BITS-1:0] out_sat;
    logic                         out_clip;

    // Section type and coefficient selection.
    assign is_hp    = (sec_reg < HP_SECTIONS);
    assign sec_last = (sec_reg == LAST_SEC);
    assign coef_b0  = is_hp ? hp_b0_reg : lp_b0_reg;
    assign coef_a1  = is_hp ? hp_a1_reg : lp_a1_reg;
    assign coef_a2  = is_hp ? hp_a2_reg : lp_a2_reg;

    // The final step of the last section retires the result unless the output is held.
    assign wr_done = (state_reg == S_WR) && sec_last && !(out_valid_reg && out_stall);

    // Shared multiplier: one half of the delay-format operand times a coefficient.
    always_comb
    begin
        x_phase  = (state_reg == S_XLO) || (state_reg == S_XHI);
        lo_phase = (state_reg == S_XLO) || (state_reg == S_A1LO) || (state_reg == S_A2LO);
        mul_src  = x_phase ? x_reg : y_reg;
        src_hi   = mul_src[DW-1:LW];
        if (lo_phase) begin
            op_a = {1'b0, mul_src[LW-1:0]};
        end
        else begin
            op_a = OW'(src_hi);
        end
        if (x_phase) begin
            op_c = coef_b0;
        end
        else if ((state_reg == S_A1LO) || (state_reg == S_A1HI)) begin
            op_c = coef_a1;
        end
        else begin
            op_c = coef_a2;
        end
        mul_prod = op_a * op_c;
    end

    // Accumulation, rounding and section sums.
    always_comb
    begin
        mult_ext   = AW'(mult_reg);
        mult_shift = mult_ext <<< LW;
        acc_rb0    = acc_reg + RND_S30;
        acc_rb1    = acc_reg + RND_S29;
        pb0_val    = acc_rb0[AW-1:COEF_FRAC];
        pb1_val    = acc_rb1[AW-1:COEF_FRAC-1];
        pb1_ext    = (DW + 4)'(pb1_val);
        pb1_next   = is_hp ? -pb1_ext : pb1_ext;
        pa_val     = acc_reg[AW-1:COEF_FRAC];
        y_sum      = SW'(pb0_reg) + SW'(z1_reg[sec_reg]);
        n1_sum     = SW'(pb1_reg) - SW'(pa_val) + SW'(z2_reg[sec_reg]);
        n2_sum     = SW'(pb0_reg) - SW'(pa_val);
    end

    // Output rounding and clamp of the last section's output.
    always_comb
    begin
        out_sum = (DW + 1)'(y_reg) + RND_OUT;
        out_rnd = out_sum[DW:GUARD_FRAC];
        if (out_rnd > RW'(SMAX)) begin
            out_sat  = SMAX;
            out_clip = 1'b1;
        end
        else if (out_rnd < RW'(SMIN)) begin
            out_sat  = SMIN;
            out_clip = 1'b1;
        end
        else begin
            out_sat  = out_rnd[SAMPLE_BITS-1:0];
            out_clip = 1'b0;
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end
        else begin
            state_reg <= state_next;
        end
    end

    // Next state and handshake outputs.
    always_comb
    begin
        state_next = state_reg;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_XLO;
            S_XLO:   state_next = S_XHI;
            S_XHI:   state_next = S_XACC;
            S_XACC:  state_next = S_RND;
            S_RND:   state_next = S_Y;
            S_Y:     state_next = S_A1LO;
            S_A1LO:  state_next = S_A1HI;
            S_A1HI:  state_next = S_A2LO;
            S_A2LO:  state_next = S_A2HI;
            S_A2HI:  state_next = S_A2ACC;
            S_A2ACC: state_next = S_WR;
            S_WR:
            begin
                if (!sec_last) begin
                    state_next = S_XLO;
                end
                else if (wr_done) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control state, filter delays, coefficients and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sec_reg       <= '0;
            out_valid_reg <= 1'b0;
            hp_b0_reg     <= B0_RESET;
            hp_a1_reg     <= A_RESET;
            hp_a2_reg     <= A_RESET;
            lp_b0_reg     <= B0_RESET;
            lp_a1_reg     <= A_RESET;
            lp_a2_reg     <= A_RESET;
            for (int i = 0; i < NUM_SECTIONS; i++) begin
                z1_reg[i] <= '0;
                z2_reg[i] <= '0;
            end
        end
        else begin
            // Section counter.
            if ((state_reg == S_IDLE) && in_valid) begin
                sec_reg <= '0;
            end
            else if ((state_reg == S_WR) && !sec_last) begin
                sec_reg <= sec_reg + 1'b1;
            end

            // Delay updates of the current section.
            if (state_reg == S_A2HI) begin
                z1_reg[sec_reg] <= sat_dw(n1_sum);
            end
            if (state_reg == S_WR) begin
                z2_reg[sec_reg] <= sat_dw(n2_sum);
            end

            // Output valid: set on retire, cleared when the result is taken.
            if (wr_done) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall) begin
                out_valid_reg <= 1'b0;
            end

            // Coefficient writes; unknown indexes are ignored.
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_HP_B0: hp_b0_reg <= signed'(cfg_data);
                    CFG_HP_A1: hp_a1_reg <= signed'(cfg_data);
                    CFG_HP_A2: hp_a2_reg <= signed'(cfg_data);
                    CFG_LP_B0: lp_b0_reg <= signed'(cfg_data);
                    CFG_LP_A1: lp_a1_reg <= signed'(cfg_data);
                    CFG_LP_A2: lp_a2_reg <= signed'(cfg_data);
                    default:   ;
                endcase
            end
        end
    end

    // Datapath payload registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    x_reg <= DW'(sample_in) <<< GUARD_FRAC;
                end
            end
            S_XLO, S_A1LO:
            begin
                mult_reg <= mul_prod;
            end
            S_XHI:
            begin
                mult_reg <= mul_prod;
                acc_reg  <= mult_ext;
            end
            S_A1HI, S_A2HI:
            begin
                mult_reg <= mul_prod;
                acc_reg  <= mult_ext + RND_S30;
            end
            S_A2LO:
            begin
                mult_reg <= mul_prod;
                acc_reg  <= acc_reg + mult_shift;
            end
            S_XACC, S_A2ACC:
            begin
                acc_reg <= acc_reg + mult_shift;
            end
            S_RND:
            begin
                pb0_reg <= pb0_val;
                pb1_reg <= pb1_next;
            end
            S_Y:
            begin
                y_reg <= sat_dw(y_sum);
            end
            S_WR:
            begin
                x_reg <= y_reg;
                if (wr_done) begin
                    sample_out_reg <= out_sat;
                    clipped_reg    <= out_clip;
                end
            end
            default: ;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;
    assign cfg_ready  = 1'b1;

endmodule

// File: hw/rtl/bbc_checker.sv
// ----------------------------------------------------------------------------
// Biquad band-pass cascade port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "biquad_bandpass_cascade_top_macros.svh"

module bbc_checker
    import bbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] sample_out,
    input logic                          clipped
);

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

    // An accepted request keeps the block busy on the following cycle.
    `BBC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // A clipped result sits at one end of the sample range.
    `BBC_ASSERT_NOW(a_clip_at_limit, clk, rst_n, out_valid && clipped, sample_out == SMAX || sample_out == SMIN)

    // A new result appears only as the computation that made it finishes.
    `BBC_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

    // A stalled result stays in place.
    `BBC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(sample_out) && $stable(clipped))

endmodule

bind biquad_bandpass_cascade_top bbc_checker #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_bbc_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample_out(sample_out),
    .clipped(clipped)
);
